### src/ts2ep_pkg.sv
// Shared types and constants for the timestamp text to epoch seconds converter.
// Holds the request and result payload structs, register indexes and arithmetic constants.
// No dependencies.
package ts2ep_pkg;

    localparam int TEXT_LEN = 19;
    localparam int EPOCH_YEAR = 1970;
    localparam int LEAPS_BEFORE_EPOCH = 477;
    localparam int DAYS_PER_YEAR = 365;
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN = 60;
    localparam int DIV100_MUL = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int ZONE_W = 5;
    localparam int EPOCH_W = 39;

    localparam logic [CFG_INDEX_W-1:0] CFG_DATE_ORDER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_OFFSET = 2'd1;

    localparam logic ORDER_YMD = 1'b0;
    localparam logic ORDER_DMY = 1'b1;
    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 5'sd8;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_DASH = 8'h2D;

    typedef enum logic [2:0] {
        FLD_SEP,
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MIN,
        FLD_SEC
    } field_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       start_req;
    } ts2ep_in_t;

    typedef struct packed {
        logic signed [EPOCH_W-1:0] epoch_seconds;
        logic                      format_error;
    } ts2ep_out_t;

endpackage

### src/timestamp_text_to_epoch_seconds.sv
// Top level of the timestamp text to epoch seconds converter.
// Depends on ts2ep_pkg for payload types, register indexes and constants.
//
//  channel | ports                              | carries
//  s_      | s_valid s_ready s_data             | one text character per request
//  m_      | m_valid m_ready m_data             | seconds and error flag per timestamp
//  cfg_    | cfg_valid cfg_ready cfg_index/data | register writes, always ready
//
// One character is taken per cycle unless the last character of a timestamp meets a stalled
// capture stage; the result of a timestamp passes through the capture, divide-by-100, day count
// and seconds registers. Reset clears the text state and loads the register defaults.
// A stalled result holds the pipeline only back to the first free stage; characters
// that do not end a timestamp are always taken.
module timestamp_text_to_epoch_seconds (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  ts2ep_pkg::ts2ep_in_t                   s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output ts2ep_pkg::ts2ep_out_t                  m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ts2ep_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ts2ep_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ts2ep_pkg::*;

    function automatic field_t field_of(input logic order, input logic [4:0] pos);
        field_t f;
        f = FLD_SEP;
        if (order == ORDER_YMD) begin
            case (pos) inside
                5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
                5'd5, 5'd6:             f = FLD_MONTH;
                5'd8, 5'd9:             f = FLD_DAY;
                5'd11, 5'd12:           f = FLD_HOUR;
                5'd14, 5'd15:           f = FLD_MIN;
                5'd17, 5'd18:           f = FLD_SEC;
                default:                f = FLD_SEP;
            endcase
        end else begin
            case (pos) inside
                5'd0, 5'd1:             f = FLD_DAY;
                5'd3, 5'd4:             f = FLD_MONTH;
                5'd6, 5'd7, 5'd8, 5'd9: f = FLD_YEAR;
                5'd11, 5'd12:           f = FLD_HOUR;
                5'd14, 5'd15:           f = FLD_MIN;
                5'd17, 5'd18:           f = FLD_SEC;
                default:                f = FLD_SEP;
            endcase
        end
        return f;
    endfunction

    function automatic logic [13:0] push_year(input logic [13:0] v, input logic [3:0] d);
        logic [17:0] t;
        t = {4'b0, v} * 18'd10 + {14'b0, d};
        return t[13:0];
    endfunction

    function automatic logic [6:0] push_two(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] t;
        t = {4'b0, v} * 11'd10 + {7'b0, d};
        return t[6:0];
    endfunction

    function automatic logic [8:0] days_before(input logic [6:0] month);
        logic [8:0] r;
        case (month)
            7'd2:    r = 9'd31;
            7'd3:    r = 9'd59;
            7'd4:    r = 9'd90;
            7'd5:    r = 9'd120;
            7'd6:    r = 9'd151;
            7'd7:    r = 9'd181;
            7'd8:    r = 9'd212;
            7'd9:    r = 9'd243;
            7'd10:   r = 9'd273;
            7'd11:   r = 9'd304;
            7'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic                     date_order_reg;
    logic signed [ZONE_W-1:0] zone_reg;

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic        bad_reg, bad_next;
    logic        text_active;
    logic        text_last;
    logic        is_digit;
    logic [3:0]  digit_val;
    field_t      fld;
    logic        in_accept;

    logic                     snap_valid_reg;
    logic [13:0]              snap_year_reg;
    logic [6:0]               snap_month_reg, snap_day_reg;
    logic [6:0]               snap_hour_reg, snap_min_reg, snap_sec_reg;
    logic signed [ZONE_W-1:0] snap_zone_reg;
    logic                     snap_bad_reg;

    logic               q_valid_reg;
    logic [13:0]        q_year_reg;
    logic [6:0]         q_month_reg, q_day_reg;
    logic [7:0]         q_qm_reg;
    logic signed [20:0] q_tsec_reg;
    logic               q_bad_reg;
    logic [13:0]        s2_m;
    logic [26:0]        s2_prod;
    logic signed [8:0]  s2_hz;
    logic signed [20:0] s2_tsec;

    logic               days_valid_reg;
    logic signed [23:0] days_reg;
    logic signed [20:0] days_tsec_reg;
    logic               days_bad_reg;
    logic [13:0]        s3_m;
    logic [14:0]        s3_q100;
    logic [13:0]        s3_rm_w;
    logic [6:0]         s3_rm;
    logic [13:0]        s3_leaps;
    logic [12:0]        s3_cnt;
    logic               s3_leap;
    logic               s3_leap_add;
    logic signed [23:0] s3_yd;
    logic signed [23:0] s3_days;

    logic                      out_valid_reg;
    ts2ep_out_t                out_reg;
    logic signed [EPOCH_W-1:0] s4_secs;

    logic out_ready, days_ready, q_ready, snap_ready;

    assign out_ready  = !out_valid_reg || m_ready;
    assign days_ready = !days_valid_reg || out_ready;
    assign q_ready    = !q_valid_reg || days_ready;
    assign snap_ready = !snap_valid_reg || q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            date_order_reg <= ORDER_YMD;
            zone_reg <= ZONE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DATE_ORDER:  date_order_reg <= cfg_data[0];
                CFG_ZONE_OFFSET: zone_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        if (s_data.start_req) begin
            pos_next = '0;
            year_next = '0;
            month_next = '0;
            day_next = '0;
            hour_next = '0;
            min_next = '0;
            sec_next = '0;
            bad_next = 1'b0;
        end else begin
            pos_next = pos_reg;
            year_next = year_reg;
            month_next = month_reg;
            day_next = day_reg;
            hour_next = hour_reg;
            min_next = min_reg;
            sec_next = sec_reg;
            bad_next = bad_reg;
        end
        text_active = pos_next < 5'(TEXT_LEN);
        text_last = pos_next == 5'(TEXT_LEN - 1);
        fld = field_of(date_order_reg, pos_next);
        is_digit = (s_data.char_byte >= ASCII_ZERO) && (s_data.char_byte <= ASCII_NINE);
        digit_val = is_digit ? 4'(s_data.char_byte - ASCII_ZERO) : 4'd0;
        if (fld == FLD_YEAR && s_data.char_byte == ASCII_DASH) begin
            year_next = year_next;
        end else if (fld != FLD_SEP && !is_digit) begin
            bad_next = 1'b1;
        end else begin
            unique case (fld)
                FLD_YEAR:  year_next = push_year(year_next, digit_val);
                FLD_MONTH: month_next = push_two(month_next, digit_val);
                FLD_DAY:   day_next = push_two(day_next, digit_val);
                FLD_HOUR:  hour_next = push_two(hour_next, digit_val);
                FLD_MIN:   min_next = push_two(min_next, digit_val);
                FLD_SEC:   sec_next = push_two(sec_next, digit_val);
                default: ;
            endcase
        end
        if (text_active) begin
            pos_next = pos_next + 5'd1;
        end
    end

    assign s_ready = !text_last || snap_ready;
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            year_reg <= '0;
            month_reg <= '0;
            day_reg <= '0;
            hour_reg <= '0;
            min_reg <= '0;
            sec_reg <= '0;
            bad_reg <= 1'b0;
        end else if (in_accept && text_active) begin
            pos_reg <= pos_next;
            year_reg <= year_next;
            month_reg <= month_next;
            day_reg <= day_next;
            hour_reg <= hour_next;
            min_reg <= min_next;
            sec_reg <= sec_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            snap_valid_reg <= in_accept && text_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && in_accept && text_last) begin
            snap_year_reg <= year_next;
            snap_month_reg <= month_next;
            snap_day_reg <= day_next;
            snap_hour_reg <= hour_next;
            snap_min_reg <= min_next;
            snap_sec_reg <= sec_next;
            snap_zone_reg <= zone_reg;
            snap_bad_reg <= bad_next;
        end
    end

    always_comb begin
        s2_m = snap_year_reg - 14'd1;
        s2_prod = {13'b0, s2_m} * 27'(DIV100_MUL);
        s2_hz = $signed({2'b00, snap_hour_reg}) - 9'(snap_zone_reg);
        s2_tsec = 21'(s2_hz) * 21'sd3600
                + $signed({14'b0, snap_min_reg}) * 21'(SECS_PER_MIN)
                + $signed({14'b0, snap_sec_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (q_ready) begin
            q_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && snap_valid_reg) begin
            q_year_reg <= snap_year_reg;
            q_month_reg <= snap_month_reg;
            q_day_reg <= snap_day_reg;
            q_qm_reg <= s2_prod[DIV100_SHIFT +: 8];
            q_tsec_reg <= s2_tsec;
            q_bad_reg <= snap_bad_reg;
        end
    end

    always_comb begin
        s3_m = q_year_reg - 14'd1;
        s3_q100 = {7'b0, q_qm_reg} * 15'd100;
        s3_rm_w = s3_m - s3_q100[13:0];
        s3_rm = s3_rm_w[6:0];
        s3_leaps = {2'b0, s3_m[13:2]} - {6'b0, q_qm_reg} + {8'b0, q_qm_reg[7:2]};
        s3_cnt = (q_year_reg > 14'(EPOCH_YEAR))
               ? 13'(s3_leaps - 14'(LEAPS_BEFORE_EPOCH)) : 13'd0;
        s3_leap = (q_year_reg[1:0] == 2'd0 && s3_rm != 7'd99)
               || (s3_rm == 7'd99 && q_qm_reg[1:0] == 2'd3);
        s3_leap_add = s3_leap && q_month_reg >= 7'd3 && q_month_reg <= 7'd12;
        s3_yd = $signed({10'b0, q_year_reg}) - 24'(EPOCH_YEAR);
        s3_days = s3_yd * 24'(DAYS_PER_YEAR)
                + $signed({11'b0, s3_cnt})
                + $signed({17'b0, q_day_reg})
                - 24'sd1
                + $signed({15'b0, days_before(q_month_reg)})
                + $signed({23'b0, s3_leap_add});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            days_valid_reg <= 1'b0;
        end else if (days_ready) begin
            days_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (days_ready && q_valid_reg) begin
            days_reg <= s3_days;
            days_tsec_reg <= q_tsec_reg;
            days_bad_reg <= q_bad_reg;
        end
    end

    assign s4_secs = EPOCH_W'(days_reg) * EPOCH_W'(SECS_PER_DAY) + EPOCH_W'(days_tsec_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= days_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && days_valid_reg) begin
            out_reg.epoch_seconds <= days_bad_reg ? '0 : s4_secs;
            out_reg.format_error <= days_bad_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    a_last_char_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && text_last) |=> snap_valid_reg)
        else $error("Final character was not captured for the seconds pipeline.");

    a_start_restarts_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_data.start_req) |=> (pos_reg == 5'd1))
        else $error("A start request did not restart the character position.");

    a_days_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (days_valid_reg && !out_ready) |=> (days_valid_reg && $stable(days_reg)))
        else $error("Day count stage changed while the result stage was stalled.");

    a_error_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.format_error) |-> (m_data.epoch_seconds == '0))
        else $error("A result with a format error carries nonzero seconds.");
`endif

endmodule

### test/timestamp_text_to_epoch_seconds_test.sv
// Testbench for timestamp_text_to_epoch_seconds: streams timestamp text under several register
// settings and checks every result against a scoreboard that predicts the converter.
// Depends on ts2ep_pkg and the RTL of timestamp_text_to_epoch_seconds.
module timestamp_text_to_epoch_seconds_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ts2ep_pkg::*;

    localparam int PHASE_COUNT = 8;
    localparam int CHARS_PER_PHASE = 125;
    localparam int MAX_WAIT = 10;
    localparam int SETTLE_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 1000;

    class epoch_checker;
        logic                     date_order;
        logic signed [ZONE_W-1:0] zone_hours;
        int                       char_pos;
        logic [13:0]              year_digits;
        logic [6:0]               month_digits;
        logic [6:0]               day_digits;
        logic [6:0]               hour_digits;
        logic [6:0]               minute_digits;
        logic [6:0]               second_digits;
        logic                     bad_digit;
        ts2ep_out_t               expected_results[$];
        int                       fail_count;

        function new();
            date_order = ORDER_YMD;
            zone_hours = ZONE_RESET;
            fail_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            char_pos = 0;
            year_digits = '0;
            month_digits = '0;
            day_digits = '0;
            hour_digits = '0;
            minute_digits = '0;
            second_digits = '0;
            bad_digit = 1'b0;
        endfunction

        static function field_t position_field(logic order, int pos);
            field_t f;
            f = FLD_SEP;
            case (pos)
                11, 12: f = FLD_HOUR;
                14, 15: f = FLD_MIN;
                17, 18: f = FLD_SEC;
                default: begin
                    if (order == ORDER_YMD) begin
                        case (pos)
                            0, 1, 2, 3: f = FLD_YEAR;
                            5, 6: f = FLD_MONTH;
                            8, 9: f = FLD_DAY;
                            default: f = FLD_SEP;
                        endcase
                    end else begin
                        case (pos)
                            0, 1: f = FLD_DAY;
                            3, 4: f = FLD_MONTH;
                            6, 7, 8, 9: f = FLD_YEAR;
                            default: f = FLD_SEP;
                        endcase
                    end
                end
            endcase
            return f;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_DATE_ORDER) begin
                date_order = data[0];
            end else if (index == CFG_ZONE_OFFSET) begin
                zone_hours = data;
            end
        endfunction

        static function longint leap_days_through(longint n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        static function bit leap_year(longint y);
            return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
        endfunction

        static function longint days_ahead_of_month(longint m);
            case (m)
                2: return 31;
                3: return 59;
                4: return 90;
                5: return 120;
                6: return 151;
                7: return 181;
                8: return 212;
                9: return 243;
                10: return 273;
                11: return 304;
                12: return 334;
                default: return 0;
            endcase
        endfunction

        function longint seconds_since_epoch();
            longint year, month, day, hour, minute, second, zone, leaps, days;
            year = year_digits;
            month = month_digits;
            day = day_digits;
            hour = hour_digits;
            minute = minute_digits;
            second = second_digits;
            zone = zone_hours;
            leaps = 0;
            if (year > EPOCH_YEAR) begin
                leaps = leap_days_through(year - 1) - leap_days_through(EPOCH_YEAR - 1);
            end
            days = (year - EPOCH_YEAR) * DAYS_PER_YEAR + leaps + day - 1;
            if (month >= 1 && month <= 12) begin
                days += days_ahead_of_month(month);
                if (month >= 3 && leap_year(year)) begin
                    days += 1;
                end
            end
            return days * SECS_PER_DAY + (hour - zone) * SECS_PER_HOUR
                 + minute * SECS_PER_MIN + second;
        endfunction

        // Returns 1 when the character is taken into a timestamp.
        function bit note_request(ts2ep_in_t req);
            field_t     f;
            bit         is_digit;
            int         d;
            ts2ep_out_t result;
            if (req.start_req) begin
                clear_text();
            end
            if (char_pos >= TEXT_LEN) begin
                return 1'b0;
            end
            f = position_field(date_order, char_pos);
            is_digit = req.char_byte >= ASCII_ZERO && req.char_byte <= ASCII_NINE;
            d = is_digit ? int'(req.char_byte - ASCII_ZERO) : 0;
            if (!(f == FLD_YEAR && req.char_byte == ASCII_DASH)) begin
                if (f != FLD_SEP && !is_digit) begin
                    bad_digit = 1'b1;
                end else begin
                    case (f)
                        FLD_YEAR: year_digits = 14'(year_digits * 10 + d);
                        FLD_MONTH: month_digits = 7'(month_digits * 10 + d);
                        FLD_DAY: day_digits = 7'(day_digits * 10 + d);
                        FLD_HOUR: hour_digits = 7'(hour_digits * 10 + d);
                        FLD_MIN: minute_digits = 7'(minute_digits * 10 + d);
                        FLD_SEC: second_digits = 7'(second_digits * 10 + d);
                        default: ;
                    endcase
                end
            end
            char_pos++;
            if (char_pos == TEXT_LEN) begin
                result.format_error = bad_digit;
                if (bad_digit) begin
                    result.epoch_seconds = '0;
                end else begin
                    result.epoch_seconds = EPOCH_W'(seconds_since_epoch());
                end
                expected_results.insert(expected_results.size(), result);
            end
            return 1'b1;
        endfunction

        task report(string what, longint got, longint want);
            $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
            fail_count++;
        endtask

        task check_result(ts2ep_out_t got);
            ts2ep_out_t want;
            if (expected_results.size() == 0) begin
                report("result with no request pending", got.epoch_seconds, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.epoch_seconds !== want.epoch_seconds) begin
                report("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
            end
            if (got.format_error !== want.format_error) begin
                report("format_error", got.format_error, want.format_error);
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    ts2ep_in_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    ts2ep_out_t             m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit                     quiet = 1'b0;
    int                     taken_chars = 0;
    int                     idle_cycles = 0;
    logic                   current_order = ORDER_YMD;
    logic [7:0]             text_chars [TEXT_LEN];
    epoch_checker           sb = new();

    timestamp_text_to_epoch_seconds uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_char(logic [7:0] c, logic start);
        ts2ep_in_t req;
        int        gap;
        req.char_byte = c;
        req.start_req = start;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = req;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_request(req)) begin
            taken_chars++;
        end
    endtask

    task automatic put_number(int first, int width, int value);
        int place;
        place = 1;
        for (int i = first + width - 1; i >= first; i--) begin
            text_chars[i] = ASCII_ZERO + 8'((value / place) % 10);
            place *= 10;
        end
    endtask

    task automatic compose_text(logic order);
        int year, month, day, hour, minute, second, pick, pos;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            year = $urandom_range(1900, 2199);
        end else if (pick < 9) begin
            year = $urandom_range(0, 9999);
        end else begin
            case ($urandom_range(0, 4))
                0: year = 0;
                1: year = 1969;
                2: year = EPOCH_YEAR;
                3: year = 2000;
                default: year = 9999;
            endcase
        end
        month = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        day = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        hour = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        minute = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        second = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        if (order == ORDER_YMD) begin
            put_number(0, 4, year);
            text_chars[4] = "-";
            put_number(5, 2, month);
            text_chars[7] = "-";
            put_number(8, 2, day);
        end else begin
            put_number(0, 2, day);
            text_chars[2] = "/";
            put_number(3, 2, month);
            text_chars[5] = "/";
            put_number(6, 4, year);
        end
        text_chars[10] = " ";
        put_number(11, 2, hour);
        text_chars[13] = ":";
        put_number(14, 2, minute);
        text_chars[16] = ":";
        put_number(17, 2, second);
        for (int i = 0; i < TEXT_LEN; i++) begin
            if (epoch_checker::position_field(order, i) == FLD_SEP
                    && $urandom_range(0, 7) == 0) begin
                text_chars[i] = 8'($urandom_range(0, 255));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            do pos = $urandom_range(0, TEXT_LEN - 1);
            while (epoch_checker::position_field(order, pos) == FLD_SEP);
            text_chars[pos] = 8'($urandom_range(0, 255));
        end else if (pick == 1) begin
            pos = (order == ORDER_YMD) ? 0 : 6;
            text_chars[pos + $urandom_range(0, 3)] = ASCII_DASH;
            if ($urandom_range(0, 1) == 0) begin
                text_chars[pos + $urandom_range(0, 3)] = ASCII_DASH;
            end
        end
    endtask

    task automatic send_text(logic order);
        int length, extra;
        compose_text(order);
        length = ($urandom_range(0, 19) == 0) ? $urandom_range(1, TEXT_LEN - 1) : TEXT_LEN;
        for (int i = 0; i < length; i++) begin
            send_char(text_chars[i], i == 0 && $urandom_range(0, 15) != 0);
        end
        extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        repeat (extra) send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_until_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        string stamp_max;
        int    zone_value;
        logic  order;
        stamp_max = "9999-12-31 23:59:59";
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DATE_ORDER;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Right after reset the text is taken without a start, then extra bytes are ignored.
        for (int i = 0; i < TEXT_LEN; i++) begin
            send_char(stamp_max[i], 1'b0);
        end
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase > 0) begin
                wait_until_idle();
                case (phase)
                    1: begin order = ORDER_DMY; zone_value = -12; end
                    2: begin order = ORDER_YMD; zone_value = 14; end
                    3: begin order = ORDER_DMY; zone_value = 0; end
                    default: begin
                        order = 1'($urandom_range(0, 1));
                        zone_value = int'($urandom_range(0, 26)) - 12;
                    end
                endcase
                write_register(CFG_ZONE_OFFSET, CFG_DATA_W'(zone_value));
                write_register(CFG_DATE_ORDER, {4'($urandom_range(0, 15)), order});
                current_order = order;
            end
            quiet = (phase == 3);
            while (taken_chars < (phase + 1) * CHARS_PER_PHASE) begin
                send_text(current_order);
            end
        end

        wait_until_idle();
        if (sb.fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### filelist.f
src/ts2ep_pkg.sv
src/timestamp_text_to_epoch_seconds.sv
test/timestamp_text_to_epoch_seconds_test.sv
